// File: hw/rtl/afrw_pkg.sv
// Shared types and constants for the AEAD frame anti-replay window.
// No dependencies; used by the bitmap RAM, the top level and the checker.
`default_nettype none

package afrw_pkg;

  localparam int BITMAP_WORDS = 1024;
  localparam int SLOT_W       = $clog2(BITMAP_WORDS);
  // block number = seq >> 6, the tag is the block number above the slot bits
  localparam int TAG_W        = 64 - 6 - SLOT_W;

  localparam logic [11:0] TAG_LEN      = 12'd16;
  localparam logic [11:0] SEAL_LEN_MAX = 12'd4079;
  localparam logic [15:0] WINDOW_MAX   = 16'((BITMAP_WORDS - 1) * 64);

  localparam logic [1:0] CFG_WINDOW     = 2'd0;
  localparam logic [1:0] CFG_NO_REPLAY  = 2'd1;
  localparam logic [1:0] CFG_HOT_STATS  = 2'd2;
  localparam logic [1:0] CFG_FLOW_EPOCH = 2'd3;

  typedef enum logic [1:0] {
    REQ_SEAL  = 2'd0,
    REQ_OPEN  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_EPOCH   = 3'd2,
    ST_AUTH    = 3'd3,
    ST_REPLAY  = 3'd4
  } status_t;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [63:0]      bits;
  } word_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
    word_t data;
  } ram_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/afrw_if.sv
// Valid/ready channel interfaces for request and response beats.
// Standalone; widths follow the frame fields.
`default_nettype none

interface afrw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] sequence_req;
  logic [63:0] epoch;
  logic [11:0] frame_len;
  logic        auth_ok;

  modport source (output valid, req_type, sequence_req, epoch, frame_len, auth_ok,
                  input ready);
  modport sink   (input valid, req_type, sequence_req, epoch, frame_len, auth_ok,
                  output ready);
endinterface

interface afrw_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] out_len;
  logic [63:0] packet_count;
  logic [63:0] byte_count;

  modport source (output valid, status, out_len, packet_count, byte_count, input ready);
  modport sink   (input valid, status, out_len, packet_count, byte_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/afrw_bitmap_ram.sv
// Seen-bit bitmap storage: one tagged 64-bit word per slot.
// One write port, one registered read port. Depends on afrw_pkg.
`default_nettype none

module afrw_bitmap_ram (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire afrw_pkg::slot_t  rd_addr,
  output afrw_pkg::word_t       rd_data,
  input  wire afrw_pkg::ram_wr_t wr
);

  afrw_pkg::word_t mem [afrw_pkg::BITMAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/aead_frame_anti_replay_window.sv
// Top level of the AEAD frame anti-replay window.
// Depends on afrw_pkg, afrw_if and afrw_bitmap_ram.
`default_nettype none

// Sequence checker for one AEAD flow. Takes one request beat per cycle unless
// a clearing pass, a flow reset beat in the check stage or a stalled response
// holds it off; one response beat per request, in order. The bitmap word of
// the sequence is read on acceptance; the check stage checks and writes it
// back (a write-forwarding register covers a back-to-back hit on the same
// word) and loads the response register. The bitmap RAM has one read and one
// write port, which sets that rate. After reset and after every flow reset
// request, a clearing pass zeroes the bitmap; no request is taken during it,
// configuration writes still are. Configuration must only change while the block is idle.
module aead_frame_anti_replay_window (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  afrw_req_if.sink         req_ch,
  afrw_rsp_if.source       rsp_ch
);

  localparam int SLOT_LO = 6;
  localparam int SLOT_HI = SLOT_LO + afrw_pkg::SLOT_W - 1;

  // configuration
  logic [15:0] win_span;
  logic        no_replay;
  logic        hot_stats;
  logic [63:0] flow_epoch;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_span   <= '0;
      no_replay  <= 1'b0;
      hot_stats  <= 1'b0;
      flow_epoch <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afrw_pkg::CFG_WINDOW:     win_span   <= cfg_data[15:0];
        afrw_pkg::CFG_NO_REPLAY:  no_replay  <= cfg_data[0];
        afrw_pkg::CFG_HOT_STATS:  hot_stats  <= cfg_data[0];
        afrw_pkg::CFG_FLOW_EPOCH: flow_epoch <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  logic [63:0]     highest;
  logic [63:0]     pkt_cnt;
  logic [63:0]     byte_cnt;
  logic            clearing;
  afrw_pkg::slot_t clr_addr;
  logic            fwd_valid;
  afrw_pkg::slot_t fwd_addr;
  afrw_pkg::word_t fwd_data;

  // check stage
  logic              s1_valid;
  afrw_pkg::req_t    s1_req;
  logic [63:0]       s1_seq;
  logic [11:0]       s1_len;
  afrw_pkg::status_t s1_pre;

  // output register
  logic              o_valid;
  afrw_pkg::status_t o_status;
  logic [11:0]       o_len;
  logic [63:0]       o_pkt;
  logic [63:0]       o_byte;

  logic              s1_adv;
  logic              accept;
  afrw_pkg::req_t    in_req;
  afrw_pkg::status_t pre_status;

  assign s1_adv = s1_valid && (!o_valid || rsp_ch.ready);
  assign req_ch.ready = !clearing &&
                        (!s1_valid || (s1_req != afrw_pkg::REQ_FLUSH && s1_adv));
  assign accept = req_ch.valid && req_ch.ready;
  assign in_req = afrw_pkg::req_t'(req_ch.req_type);

  // front checks that need no state
  always_comb begin
    pre_status = afrw_pkg::ST_OK;
    unique case (in_req)
      afrw_pkg::REQ_SEAL: begin
        if (req_ch.sequence_req == '0 || req_ch.frame_len > afrw_pkg::SEAL_LEN_MAX) begin
          pre_status = afrw_pkg::ST_INVALID;
        end else if (req_ch.epoch != flow_epoch) begin
          pre_status = afrw_pkg::ST_EPOCH;
        end
      end
      afrw_pkg::REQ_OPEN: begin
        if (req_ch.sequence_req == '0 || req_ch.frame_len < afrw_pkg::TAG_LEN) begin
          pre_status = afrw_pkg::ST_INVALID;
        end else if (req_ch.epoch != flow_epoch) begin
          pre_status = afrw_pkg::ST_EPOCH;
        end else if (!req_ch.auth_ok) begin
          pre_status = afrw_pkg::ST_AUTH;
        end
      end
      afrw_pkg::REQ_FLUSH: pre_status = afrw_pkg::ST_OK;
      afrw_pkg::REQ_RSVD:  pre_status = afrw_pkg::ST_INVALID;
      default:             pre_status = afrw_pkg::ST_INVALID;
    endcase
  end

  // bitmap RAM
  afrw_pkg::word_t   rd_data;
  afrw_pkg::ram_wr_t wr;

  afrw_bitmap_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req_ch.sequence_req[SLOT_HI:SLOT_LO]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // check and update
  afrw_pkg::slot_t            s1_slot;
  logic [afrw_pkg::TAG_W-1:0] s1_tag;
  afrw_pkg::word_t            cur_word;
  afrw_pkg::word_t            marked_word;
  logic [63:0]                bit_mask;
  logic                       stale;
  logic                       seen;
  logic                       hi_gt;
  logic [63:0]                delta;
  logic [15:0]                win_eff;
  afrw_pkg::status_t          status;
  logic                       do_mark;
  logic                       set_hi;
  logic                       ok_pkt;
  logic                       is_flush;
  logic [11:0]                plain;
  logic [11:0]                len_out;
  logic [63:0]                pkt_next;
  logic [63:0]                byte_next;

  always_comb begin
    s1_slot  = s1_seq[SLOT_HI:SLOT_LO];
    s1_tag   = s1_seq[63:SLOT_HI+1];
    cur_word = (fwd_valid && fwd_addr == s1_slot) ? fwd_data : rd_data;
    bit_mask = 64'd1 << s1_seq[5:0];
    stale    = cur_word.tag != s1_tag;
    seen     = !stale && ((cur_word.bits & bit_mask) != '0);
    if (stale) begin
      marked_word.tag  = s1_tag;
      marked_word.bits = bit_mask;
    end else begin
      marked_word.tag  = cur_word.tag;
      marked_word.bits = cur_word.bits | bit_mask;
    end

    hi_gt   = s1_seq > highest;
    delta   = highest - s1_seq;
    win_eff = (win_span == '0 || win_span > afrw_pkg::WINDOW_MAX) ?
              afrw_pkg::WINDOW_MAX : win_span;

    status  = s1_pre;
    do_mark = 1'b0;
    set_hi  = 1'b0;
    case (s1_req)
      afrw_pkg::REQ_SEAL: begin
        if (s1_pre == afrw_pkg::ST_OK) begin
          if (hi_gt) begin
            set_hi  = 1'b1;
            do_mark = 1'b1;
          end else begin
            status = afrw_pkg::ST_REPLAY;
          end
        end
      end
      afrw_pkg::REQ_OPEN: begin
        if (s1_pre == afrw_pkg::ST_OK && !no_replay) begin
          if (hi_gt) begin
            set_hi  = 1'b1;
            do_mark = 1'b1;
          end else if (delta >= {48'd0, win_eff} || seen) begin
            status = afrw_pkg::ST_REPLAY;
          end else begin
            do_mark = 1'b1;
          end
        end
      end
      default: ;
    endcase

    is_flush = s1_req == afrw_pkg::REQ_FLUSH;
    ok_pkt   = (s1_req == afrw_pkg::REQ_SEAL || s1_req == afrw_pkg::REQ_OPEN) &&
               status == afrw_pkg::ST_OK;
    plain    = (s1_req == afrw_pkg::REQ_SEAL) ? s1_len : s1_len - afrw_pkg::TAG_LEN;
    if (!ok_pkt) begin
      len_out = '0;
    end else if (s1_req == afrw_pkg::REQ_SEAL) begin
      len_out = s1_len + afrw_pkg::TAG_LEN;
    end else begin
      len_out = plain;
    end

    if (is_flush) begin
      pkt_next  = '0;
      byte_next = '0;
    end else if (ok_pkt && hot_stats) begin
      pkt_next  = pkt_cnt + 64'd1;
      byte_next = byte_cnt + {52'd0, plain};
    end else begin
      pkt_next  = pkt_cnt;
      byte_next = byte_cnt;
    end

    wr.en   = clearing || (s1_adv && do_mark);
    wr.addr = clearing ? clr_addr : s1_slot;
    wr.data = clearing ? '0 : marked_word;
  end

  // request into the check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_req <= in_req;
      s1_seq <= req_ch.sequence_req;
      s1_len <= req_ch.frame_len;
      s1_pre <= pre_status;
    end
  end

  // flow state, clearing pass and write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      highest   <= '0;
      pkt_cnt   <= '0;
      byte_cnt  <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == afrw_pkg::SLOT_W'(afrw_pkg::BITMAP_WORDS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (s1_adv) begin
        pkt_cnt  <= pkt_next;
        byte_cnt <= byte_next;
        if (is_flush) begin
          highest   <= '0;
          clearing  <= 1'b1;
          clr_addr  <= '0;
          fwd_valid <= 1'b0;
        end else begin
          if (set_hi) begin
            highest <= s1_seq;
          end
          if (do_mark) begin
            fwd_valid <= 1'b1;
          end
        end
      end
    end
    if (s1_adv && do_mark) begin
      fwd_addr <= s1_slot;
      fwd_data <= marked_word;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      o_valid <= 1'b0;
    end
    if (s1_adv) begin
      o_status <= status;
      o_len    <= len_out;
      o_pkt    <= pkt_next;
      o_byte   <= byte_next;
    end
  end

  assign rsp_ch.valid        = o_valid;
  assign rsp_ch.status       = o_status;
  assign rsp_ch.out_len      = o_len;
  assign rsp_ch.packet_count = o_pkt;
  assign rsp_ch.byte_count   = o_byte;

endmodule

`default_nettype wire

// File: hw/rtl/afrw_checker.sv
// Port-level assertions for the anti-replay window, bound to the top level.
// Depends on afrw_pkg and aead_frame_anti_replay_window.
`default_nettype none

module afrw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [11:0] out_len
);

  // reset starts the bitmap clearing pass
  a_rst_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken right after reset");

  // a flow reset beat stalls requests until its clearing pass is done
  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_req_type == afrw_pkg::REQ_FLUSH) |=> !in_ready)
    else $error("request taken behind a flow reset");

  // every error response carries a zero length
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != afrw_pkg::ST_OK) |-> out_len == '0)
    else $error("nonzero length on error response");

  // a fresh response traces back to an accepted request through the check stage
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("response without matching request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_len)))
    else $error("stalled response changed");

endmodule

bind aead_frame_anti_replay_window afrw_checker u_afrw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req_ch.valid),
  .in_ready    (req_ch.ready),
  .in_req_type (req_ch.req_type),
  .out_valid   (rsp_ch.valid),
  .out_ready   (rsp_ch.ready),
  .out_status  (rsp_ch.status),
  .out_len     (rsp_ch.out_len)
);

`default_nettype wire
